// File: src/bdcc_pkg.sv
package bdcc_pkg;

    // Lane count and timer width
    localparam int NUM_BUTTONS = 2;
    localparam int TIMER_WIDTH = 8;

    // Configuration registers are 8 bits wide
    localparam int CFG_W   = 8;
    localparam int CMP_W   = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam int TALLY_W = 3;
    localparam int CODE_W  = 2;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [TALLY_W-1:0]     TALLY_MAX = TALLY_W'(4);

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(2);
    localparam logic [CFG_W-1:0] WINDOW_RST   = CFG_W'(30);
    localparam logic [CFG_W-1:0] HOLDOFF_RST  = CFG_W'(10);
    localparam logic [CFG_W-1:0] STARTUP_RST  = CFG_W'(20);

    typedef logic [TIMER_WIDTH-1:0] t_timer;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_WINDOW   = 2'd1,
        REG_HOLDOFF  = 2'd2,
        REG_STARTUP  = 2'd3
    } t_cfg_idx;

    // Click sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_HOLD  = 2'd2
    } t_phase;

    // Click codes
    localparam logic [CODE_W-1:0] CODE_NONE = CODE_W'(0);

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] click_window_ticks;
        logic [CFG_W-1:0] holdoff_ticks;
        logic [CFG_W-1:0] startup_ticks;
    } t_cfg;

    // Per-lane result of one beat
    typedef struct packed {
        logic              level;
        logic              press;
        logic              release_ev;
        logic [CODE_W-1:0] code;
    } t_lane_ev;

    // Saturating timer increment
    function automatic t_timer sat_inc(input t_timer v);
        sat_inc = (v == TIMER_MAX) ? v : v + t_timer'(1);
    endfunction

    // Timer compared against an 8-bit register
    function automatic logic timer_ge(input t_timer t, input logic [CFG_W-1:0] lim);
        timer_ge = CMP_W'(t) >= CMP_W'(lim);
    endfunction

endpackage

// File: src/bdcc_lane.sv
module bdcc_lane
    import bdcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_tick,
    input  logic     i_pressed,
    input  t_cfg     i_cfg,
    output t_lane_ev o_ev
);

    logic               r_mark,  n_mark;
    logic               r_level, n_level;
    logic               r_prev,  n_prev;
    t_timer             r_run,   n_run;
    t_phase             r_phase, n_phase;
    logic [TALLY_W-1:0] r_tally, n_tally;
    t_timer             r_timer, n_timer;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= 1'b0;
            r_level <= 1'b0;
            r_prev  <= 1'b0;
            r_run   <= '0;
            r_phase <= PH_IDLE;
            r_tally <= '0;
            r_timer <= '0;
        end else begin
            r_mark  <= n_mark;
            r_level <= n_level;
            r_prev  <= n_prev;
            r_run   <= n_run;
            r_phase <= n_phase;
            r_tally <= n_tally;
            r_timer <= n_timer;
        end
    end

    // Debounce, edge detect and click sequencing for one beat
    always_comb begin
        logic               agree;
        t_timer             run_inc;
        logic [TALLY_W-1:0] tally_cur;

        agree     = ~r_level;
        run_inc   = sat_inc(r_run);
        tally_cur = r_tally;

        n_mark  = r_mark;
        n_level = r_level;
        n_prev  = r_prev;
        n_run   = r_run;
        n_phase = r_phase;
        n_tally = r_tally;
        n_timer = r_timer;

        o_ev.press      = 1'b0;
        o_ev.release_ev = 1'b0;
        o_ev.code       = CODE_NONE;

        if (i_step) begin
            // Window mark: while the level is low, released clears it; while high, pressed sets it
            if (!r_level) begin
                if (!i_pressed) n_mark = 1'b0;
            end else begin
                if (i_pressed) n_mark = 1'b1;
            end

            if (i_tick) begin
                // Whole window disagreed with the level: extend the run, flip at the debounce limit
                if (n_mark == agree) begin
                    if (timer_ge(run_inc, i_cfg.debounce_ticks)) begin
                        n_level = agree;
                        n_run   = '0;
                    end else begin
                        n_run = run_inc;
                    end
                end else begin
                    n_mark = agree;
                    n_run  = '0;
                end

                // Edge events on the debounced level
                if (!r_prev && n_level) begin
                    o_ev.press = 1'b1;
                    n_prev     = 1'b1;
                end else if (r_prev && !n_level) begin
                    o_ev.release_ev = 1'b1;
                    n_prev          = 1'b0;
                end

                // Click sequencer
                case (r_phase)
                    PH_COUNT: begin
                        if (o_ev.press && (r_tally < TALLY_MAX)) begin
                            tally_cur = r_tally + TALLY_W'(1);
                        end
                        if (timer_ge(r_timer, i_cfg.click_window_ticks)) begin
                            if (tally_cur >= TALLY_W'(1) && tally_cur <= TALLY_W'(3)) begin
                                o_ev.code = tally_cur[CODE_W-1:0];
                            end
                            n_timer = '0;
                            n_tally = '0;
                            n_phase = PH_HOLD;
                        end else begin
                            n_tally = tally_cur;
                            n_timer = sat_inc(r_timer);
                        end
                    end
                    PH_HOLD: begin
                        if (timer_ge(r_timer, i_cfg.holdoff_ticks)) begin
                            n_phase = PH_IDLE;
                            n_timer = '0;
                        end else begin
                            n_timer = sat_inc(r_timer);
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (o_ev.press) begin
                            n_timer = '0;
                            n_tally = TALLY_W'(1);
                            n_phase = PH_COUNT;
                        end
                    end
                endcase
            end
        end

        o_ev.level = n_level;
    end

endmodule

// File: src/bdcc_startup.sv
module bdcc_startup
    import bdcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_tick,
    input  logic             i_pressed,
    input  logic [CFG_W-1:0] i_startup_ticks,
    output logic             o_active,
    output logic             o_active_next
);

    logic   r_active, n_active;
    logic   r_mark,   n_mark;
    t_timer r_timer,  n_timer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_mark   <= 1'b0;
            r_timer  <= '0;
        end else begin
            r_active <= n_active;
            r_mark   <= n_mark;
            r_timer  <= n_timer;
        end
    end

    // Release check over start-up windows on button 0, repeated until one window passes with no press
    always_comb begin
        n_active = r_active;
        n_mark   = r_mark;
        n_timer  = r_timer;
        if (i_step && r_active) begin
            if (i_tick) n_timer = sat_inc(r_timer);
            if (i_pressed) n_mark = 1'b1;
            if (timer_ge(n_timer, i_startup_ticks)) begin
                n_timer = '0;
                if (!n_mark) n_active = 1'b0;
                n_mark = 1'b0;
            end
        end
    end

    assign o_active      = r_active;
    assign o_active_next = n_active;

endmodule

// File: src/button_debounce_click_classifier.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   i_s_tvalid / o_s_tready   i_s_tdata: raw_button_a, raw_button_b, tick
// m_axis    out  o_m_tvalid / i_m_tready   o_m_tdata: stable, press, release, click, starting
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat per cycle while o_s_tready is high: after start-up, each button lane updates its state in the
// accept cycle, and the merged result sits in a single output register from the next cycle.
// o_s_tready drops only while that output register is full and i_m_tready is low.
// Synchronous active-low reset; after reset the block holds in start-up until a
// start-up window passes with button 0 released. The cfg port is always ready.
module button_debounce_click_classifier
    import bdcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [0] raw_button_a, [1] raw_button_b, [2] tick, [7:3] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] stable_a, [1] stable_b, [2] press_a, [3] press_b, [4] release_a,
    // [5] release_b, [7:6] click_code_a, [9:8] click_code_b, [10] starting, [15:11] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_cfg r_cfg;
    logic r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic accept;
    logic tick;
    logic st_active, st_active_next;
    logic [NUM_BUTTONS-1:0] pressed;
    t_lane_ev ev [NUM_BUTTONS];
    t_lane_ev ev_a, ev_b;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign tick        = i_s_tdata[2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= DEBOUNCE_RST;
            r_cfg.click_window_ticks <= WINDOW_RST;
            r_cfg.holdoff_ticks      <= HOLDOFF_RST;
            r_cfg.startup_ticks      <= STARTUP_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_DEBOUNCE: r_cfg.debounce_ticks     <= i_cfg_data;
                REG_WINDOW:   r_cfg.click_window_ticks <= i_cfg_data;
                REG_HOLDOFF:  r_cfg.holdoff_ticks      <= i_cfg_data;
                REG_STARTUP:  r_cfg.startup_ticks      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Active-low pins; lanes past the second read as released
    always_comb begin
        pressed = '0;
        pressed[0] = ~i_s_tdata[0];
        if (NUM_BUTTONS > 1) pressed[1 % NUM_BUTTONS] = ~i_s_tdata[1];
    end

    bdcc_startup u_startup (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (accept),
        .i_tick          (tick),
        .i_pressed       (pressed[0]),
        .i_startup_ticks (r_cfg.startup_ticks),
        .o_active        (st_active),
        .o_active_next   (st_active_next)
    );

    // One lane per button
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bdcc_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (accept && !st_active),
            .i_tick    (tick),
            .i_pressed (pressed[g]),
            .i_cfg     (r_cfg),
            .o_ev      (ev[g])
        );
    end

    // Merge: lane 0 as button a, lane 1 as button b when present
    always_comb begin
        ev_a = ev[0];
        ev_b = '0;
        if (NUM_BUTTONS > 1) ev_b = ev[1 % NUM_BUTTONS];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {5'b0, st_active_next, ev_b.code, ev_a.code,
                           ev_b.release_ev, ev_a.release_ev,
                           ev_b.press, ev_a.press, ev_b.level, ev_a.level};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
